// ===== rtl/cnl_pkg.sv =====
// ----------------------------------------------------------------------------
// cnl_pkg
// Shared constants and step tables for the complex logarithm pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package cnl_pkg;

  localparam int unsigned ITERATIONS_DEF = 16;
  localparam int unsigned PRE_SHIFT      = 14;
  localparam int unsigned IN_FRAC        = 12;
  localparam int unsigned VEC_W          = 36;   // 16b input << 14, plus growth
  localparam int unsigned ANG_W          = 20;   // Q16 angle, +-pi plus slack
  localparam int unsigned MAN_W          = 31;   // Q30 mantissa in [1,2)
  localparam int unsigned EXP_W          = 6;
  localparam int unsigned LOG_W          = 24;   // Q16 log accumulator

  localparam logic signed [ANG_W-1:0] PI_Q16  = ANG_W'(205887);
  localparam logic signed [15:0]      PI_Q13  = 16'sd25736;
  localparam logic signed [LOG_W-1:0] LN2_Q16 = LOG_W'(45426);
  localparam logic signed [LOG_W-1:0] LNK_Q16 = LOG_W'(32690);

  // atan(2^-i) in Q16
  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = ANG_W'(51472);
      1: r = ANG_W'(30386);
      2: r = ANG_W'(16055);
      3: r = ANG_W'(8150);
      4: r = ANG_W'(4091);
      5: r = ANG_W'(2047);
      6: r = ANG_W'(1024);
      7: r = ANG_W'(512);
      default: r = (i <= 16) ? ANG_W'(64'd1 << (16 - i)) : '0;
    endcase
    return r;
  endfunction

  // -ln(1 - 2^-k) in Q16
  function automatic logic [LOG_W-1:0] ln_step(input int unsigned k);
    logic [LOG_W-1:0] r;
    case (k)
      1: r = LOG_W'(45426);
      2: r = LOG_W'(18854);
      3: r = LOG_W'(8751);
      4: r = LOG_W'(4230);
      5: r = LOG_W'(2081);
      6: r = LOG_W'(1032);
      7: r = LOG_W'(514);
      8: r = LOG_W'(257);
      9: r = LOG_W'(128);
      default: r = (k >= 1 && k <= 16) ? LOG_W'(64'd1 << (16 - k)) : '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/complex_natural_log.sv =====
// ----------------------------------------------------------------------------
// complex_natural_log
// Pipelined ln(z): CORDIC vectoring for phase and magnitude, then
// normalization and shift-and-add logarithm of the magnitude.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  input   | in        | valid_i/stall_o  | real_in_i, imag_in_i
//  output  | out       | valid_o/stall_i  | log_magnitude_o, phase_angle_o, zero_input_o
//
// Prescale, CORDIC, normalization, log, multiply and output registers; one transfer per cycle unless stalled.
// Every stage holds one item with its valid bit; the whole pipe advances
// when the output register is empty or being taken, so stall_o = stall_i
// with a full output stage. Reset clears valid bits only.
`default_nettype none
module complex_natural_log #(
  parameter int unsigned ITERATIONS = cnl_pkg::ITERATIONS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic signed [15:0] real_in_i,
  input  wire logic signed [15:0] imag_in_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [15:0]      log_magnitude_o,
  output logic signed [15:0]      phase_angle_o,
  output logic                    zero_input_o
);
  localparam int unsigned VW = cnl_pkg::VEC_W;
  localparam int unsigned AW = cnl_pkg::ANG_W;
  localparam int unsigned MW = cnl_pkg::MAN_W;
  localparam int unsigned EW = cnl_pkg::EXP_W;
  localparam int unsigned LW = cnl_pkg::LOG_W;
  localparam int unsigned NC = ITERATIONS + 1;   // cordic stage registers

  logic adv;
  assign adv     = !valid_o || !stall_i;
  assign stall_o = !adv;

  // ---------------- CORDIC stages ----------------
  logic                 cv_q [NC];
  logic                 cz_q [NC];
  logic signed [VW-1:0] cx_q [NC];
  logic signed [VW-1:0] cy_q [NC];
  logic signed [AW-1:0] ca_q [NC];

  // stage 0: quadrant fold and prescale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cz_q[0] <= (real_in_i == 16'sd0) && (imag_in_i == 16'sd0);
      if (real_in_i < 0) begin
        cx_q[0] <= -(VW'(real_in_i) <<< cnl_pkg::PRE_SHIFT);
        cy_q[0] <= -(VW'(imag_in_i) <<< cnl_pkg::PRE_SHIFT);
        ca_q[0] <= (imag_in_i >= 0) ? cnl_pkg::PI_Q16 : -cnl_pkg::PI_Q16;
      end else begin
        cx_q[0] <= VW'(real_in_i) <<< cnl_pkg::PRE_SHIFT;
        cy_q[0] <= VW'(imag_in_i) <<< cnl_pkg::PRE_SHIFT;
        ca_q[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cordic
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[g+1] <= 1'b0;
      end else if (adv) begin
        cv_q[g+1] <= cv_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cz_q[g+1] <= cz_q[g];
        if (!cy_q[g][VW-1]) begin
          cx_q[g+1] <= cx_q[g] + (cy_q[g] >>> g);
          cy_q[g+1] <= cy_q[g] - (cx_q[g] >>> g);
          ca_q[g+1] <= ca_q[g] + cnl_pkg::atan_step(g);
        end else begin
          cx_q[g+1] <= cx_q[g] - (cy_q[g] >>> g);
          cy_q[g+1] <= cy_q[g] + (cx_q[g] >>> g);
          ca_q[g+1] <= ca_q[g] - cnl_pkg::atan_step(g);
        end
      end
    end
  end

  // ---------------- phase rounding and normalization ----------------
  logic signed [AW-1:0] ph_full;
  logic signed [15:0]   ph_c;
  logic [VW-2:0]        mag;
  logic [EW-1:0]        msb;
  assign ph_full = (ca_q[NC-1] + AW'(4)) >>> 3;
  always_comb begin
    if (ph_full > AW'(cnl_pkg::PI_Q13))       ph_c = cnl_pkg::PI_Q13;
    else if (ph_full < -AW'(cnl_pkg::PI_Q13)) ph_c = -cnl_pkg::PI_Q13;
    else                                      ph_c = ph_full[15:0];
  end
  assign mag = (cx_q[NC-1] > 0) ? cx_q[NC-1][VW-2:0] : (VW-1)'(1);
  always_comb begin
    msb = '0;
    for (int b = 0; b < VW - 1; b++) begin
      if (mag[b]) msb = EW'(b);
    end
  end

  localparam int unsigned NL = ITERATIONS + 1;
  logic                 lv_q [NL];
  logic                 lz_q [NL];
  logic signed [15:0]   lp_q [NL];
  logic [EW-1:0]        le_q [NL];
  logic [MW-1:0]        lf_q [NL];
  logic [LW-1:0]        la_q [NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q[0] <= 1'b0;
    end else if (adv) begin
      lv_q[0] <= cv_q[NC-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lz_q[0] <= cz_q[NC-1];
      lp_q[0] <= ph_c;
      le_q[0] <= msb;
      // msb stays below 35, so left-justify into Q30
      if (msb >= EW'(30)) lf_q[0] <= MW'(mag >> (msb - EW'(30)));
      else                lf_q[0] <= MW'(mag << (EW'(30) - msb));
      la_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= ITERATIONS; k++) begin : g_log
    logic [MW-1:0] t;
    assign t = lf_q[k-1] - (lf_q[k-1] >> k);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lv_q[k] <= 1'b0;
      end else if (adv) begin
        lv_q[k] <= lv_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        lz_q[k] <= lz_q[k-1];
        lp_q[k] <= lp_q[k-1];
        le_q[k] <= le_q[k-1];
        if (t[MW-1]) begin
          lf_q[k] <= t;
          la_q[k] <= la_q[k-1] + cnl_pkg::ln_step(k);
        end else begin
          lf_q[k] <= lf_q[k-1];
          la_q[k] <= la_q[k-1];
        end
      end
    end
  end

  // ---------------- exponent term (multiply) ----------------
  logic                 mv_q, mz_q;
  logic signed [15:0]   mp_q;
  logic signed [LW-1:0] me_q;
  logic [LW-1:0]        ma_q;
  logic signed [7:0]    eoff;
  assign eoff = 8'(le_q[NL-1]) - 8'(cnl_pkg::PRE_SHIFT + cnl_pkg::IN_FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (adv) begin
      mv_q <= lv_q[NL-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mz_q <= lz_q[NL-1];
      mp_q <= lp_q[NL-1];
      me_q <= LW'(eoff) * cnl_pkg::LN2_Q16;
      ma_q <= la_q[NL-1];
    end
  end

  // ---------------- final sum, round, saturate ----------------
  logic signed [LW-1:0] lg_sum, lg_r;
  logic signed [15:0]   lg_c;
  assign lg_sum = me_q + $signed(ma_q) - cnl_pkg::LNK_Q16 + LW'(16);
  assign lg_r   = lg_sum >>> 5;
  always_comb begin
    if (lg_r > LW'(32767))        lg_c = 16'sh7fff;
    else if (lg_r < -LW'(32768))  lg_c = 16'sh8000;
    else                          lg_c = lg_r[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= mv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_input_o    <= mz_q;
      log_magnitude_o <= mz_q ? 16'sh8000 : lg_c;
      phase_angle_o   <= mz_q ? 16'sd0 : mp_q;
    end
  end

  // ---------------- assertions ----------------
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("stall without full output");
  a_zero_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_input_o) |-> (log_magnitude_o == 16'sh8000 && phase_angle_o == 16'sd0))
    else $error("zero input result wrong");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (phase_angle_o <= cnl_pkg::PI_Q13 && phase_angle_o >= -cnl_pkg::PI_Q13))
    else $error("phase out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(log_magnitude_o)))
    else $error("output changed while stalled");

endmodule
`default_nettype wire
